// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside of reset
`define NC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define NC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/ncache_pkg.sv -----
// ----------------------------------------------------------------------------
// ncache_pkg
// Shared codes and types of the node cache with recency list.
// ----------------------------------------------------------------------------
`default_nettype none
package ncache_pkg;

  // operation codes carried in tuser
  localparam logic [2:0] FN_LOOKUP     = 3'd0;
  localparam logic [2:0] FN_ADD        = 3'd1;
  localparam logic [2:0] FN_REMOVE     = 3'd2;
  localparam logic [2:0] FN_LIST_ALL   = 3'd3;
  localparam logic [2:0] FN_LIST_FLUSH = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned LIMIT_W  = 4;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 72;

  // command to the recency list
  typedef struct packed {
    logic push;   // drop id if present, then insert at front and trim
    logic drop;   // drop id if present
  } recent_cmd_t;

endpackage
`default_nettype wire

// ----- src/ncache_ram.sv -----
// ----------------------------------------------------------------------------
// ncache_ram
// Generic single write port RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module ncache_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- src/ncache_recent.sv -----
// ----------------------------------------------------------------------------
// ncache_recent
// Recency list of ids, newest first, with drop, push and membership probe.
// ----------------------------------------------------------------------------
`default_nettype none
module ncache_recent #(
  parameter int RECENT_DEPTH = 8,
  parameter int ID_BITS      = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ncache_pkg::recent_cmd_t     cmd,
  input  wire logic [ID_BITS-1:0]          cmd_id,
  input  wire logic [ncache_pkg::LIMIT_W-1:0] limit,
  input  wire logic [ID_BITS-1:0]          probe_id,
  output logic                             probe_hit
);
  import ncache_pkg::*;

  localparam int CNT_W = $clog2(RECENT_DEPTH + 1);
  localparam int IDX_W = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
  localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  logic [ID_BITS-1:0] ids_r [RECENT_DEPTH];
  logic [CNT_W-1:0]   cnt_r;

  logic               m_hit;
  logic [IDX_W-1:0]   m_idx;
  logic [ID_BITS-1:0] drop_ids [RECENT_DEPTH];
  logic [ID_BITS-1:0] push_ids [RECENT_DEPTH];
  logic [CNT_W-1:0]   cnt_drop;
  logic [CNT_W-1:0]   cnt_push;
  logic [LIM_W-1:0]   lim_c;

  // first live entry matching the command id
  always_comb begin
    m_hit = 1'b0;
    m_idx = '0;
    for (int i = RECENT_DEPTH - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < cnt_r) && (ids_r[i] == cmd_id)) begin
        m_hit = 1'b1;
        m_idx = IDX_W'(i);
      end
    end
  end

  // close the gap left by a dropped entry
  always_comb begin
    for (int j = 0; j < RECENT_DEPTH; j++) begin
      drop_ids[j] = ids_r[j];
      if (j + 1 < RECENT_DEPTH) begin
        if (m_hit && (IDX_W'(j) >= m_idx)) begin
          drop_ids[j] = ids_r[j + 1];
        end
      end
    end
    cnt_drop = cnt_r - CNT_W'(m_hit);
  end

  // shift in at the front and trim to the clamped limit
  always_comb begin
    push_ids[0] = cmd_id;
    for (int j = 1; j < RECENT_DEPTH; j++) begin
      push_ids[j] = drop_ids[j - 1];
    end
    lim_c = LIM_W'(limit);
    if (lim_c == '0) begin
      lim_c = LIM_W'(1);
    end
    if (lim_c > LIM_W'(RECENT_DEPTH)) begin
      lim_c = LIM_W'(RECENT_DEPTH);
    end
    cnt_push = (cnt_drop < CNT_W'(RECENT_DEPTH)) ? cnt_drop + CNT_W'(1) : cnt_drop;
    if (LIM_W'(cnt_push) > lim_c) begin
      cnt_push = CNT_W'(lim_c);
    end
  end

  // membership of the probed id
  always_comb begin
    probe_hit = 1'b0;
    for (int i = 0; i < RECENT_DEPTH; i++) begin
      if ((CNT_W'(i) < cnt_r) && (ids_r[i] == probe_id)) begin
        probe_hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.push) begin
      cnt_r <= cnt_push;
    end else if (cmd.drop) begin
      cnt_r <= cnt_drop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ids_r <= push_ids;
    end else if (cmd.drop) begin
      ids_r <= drop_ids;
    end
  end

endmodule
`default_nettype wire

// ----- src/node_cache_with_recency_list_core.sv -----
// Lookup, add and remove scan the slot RAM one slot at a time
//   (read, then compare), stopping at a hit.
// List operations always scan all slots and may be held by output stalls.
// One operation is in flight at a time; the slot RAM read port sets the pace.
// Reset (rst_n low, synchronous) empties the table and recency list, limit = 8.
// ----------------------------------------------------------------------------
// node_cache_with_recency_list_core
// Node id to handle table in a RAM, with a recency list of recent adds.
// ----------------------------------------------------------------------------
`default_nettype none
module node_cache_with_recency_list_core #(
  parameter int TABLE_DEPTH  = 32,
  parameter int RECENT_DEPTH = 8,
  parameter int ID_BITS      = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // tdata: node_id[31:0], node_handle[63:32]
  input  wire logic [ncache_pkg::IN_TDATA_W-1:0] in_tdata,
  // tuser: func[2:0]
  input  wire logic [ncache_pkg::FUNC_W-1:0]     in_tuser,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // tdata: status[1:0], handle_out[33:2], listed_id[65:34], zero pad[71:66]
  output logic [ncache_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // tuser: item_valid[0]
  output logic                                   out_tuser,
  output logic                                   out_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic [ncache_pkg::LIMIT_W-1:0]    cfg_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready
);
  import ncache_pkg::*;

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int RAM_W  = ID_BITS + FIELD_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_CHK  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [FUNC_W-1:0]   func_r;
  logic [ID_BITS-1:0]  id_r;
  logic [FIELD_W-1:0]  hnd_r;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic                found_r, found_nxt;
  logic [AW-1:0]       match_r, match_nxt;
  logic [FIELD_W-1:0]  mhnd_r, mhnd_nxt;
  logic                pend_r, pend_nxt;
  logic [ID_BITS-1:0]  pend_id_r, pend_id_nxt;
  logic [TABLE_DEPTH-1:0] used_r, used_nxt;
  logic [LIMIT_W-1:0]  limit_r;

  logic                out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                out_user_r, out_user_nxt;
  logic                out_last_r, out_last_nxt;

  logic [63:0]         in_id_ext;
  logic [ID_BITS-1:0]  in_id;
  logic [RAM_W-1:0]    rd_data;
  logic [ID_BITS-1:0]  rd_id;
  logic [FIELD_W-1:0]  rd_hnd;
  logic                ram_we, ram_re;
  logic                probe_hit;
  recent_cmd_t         rcmd;
  logic                out_free;
  logic                free_ok;
  logic [AW-1:0]       free_idx;
  logic                is_list, last_slot, hit, qual;
  logic [63:0]         pend_ext;

  assign in_id_ext = 64'(in_tdata[FIELD_W-1:0]);
  assign in_id     = in_id_ext[ID_BITS-1:0];
  assign rd_id     = rd_data[ID_BITS-1:0];
  assign rd_hnd    = rd_data[RAM_W-1:ID_BITS];
  assign pend_ext  = 64'(pend_id_r);

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;
  assign out_free   = !out_valid_r || out_tready;

  // slot table storage: {handle, id}
  ncache_ram #(.WIDTH(RAM_W), .DEPTH(TABLE_DEPTH)) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata ({hnd_r, id_r}),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (rd_data)
  );

  ncache_recent #(.RECENT_DEPTH(RECENT_DEPTH), .ID_BITS(ID_BITS)) u_recent (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (rcmd),
    .cmd_id    (id_r),
    .limit     (limit_r),
    .probe_id  (rd_id),
    .probe_hit (probe_hit)
  );

  // lowest free slot
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_ok  = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  assign is_list   = (func_r == FN_LIST_ALL) || (func_r == FN_LIST_FLUSH);
  assign last_slot = (idx_r == AW'(TABLE_DEPTH - 1));
  assign hit       = used_r[idx_r] && (rd_id == id_r);
  assign qual      = used_r[idx_r] && ((func_r == FN_LIST_ALL) || !probe_hit);

  // operation sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    match_nxt     = match_r;
    mhnd_nxt      = mhnd_r;
    pend_nxt      = pend_r;
    pend_id_nxt   = pend_id_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    rcmd          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          pend_nxt  = 1'b0;
          state_nxt = (in_tuser > FN_LIST_FLUSH) ? S_FIN : S_RD;
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (is_list) begin
          if (qual && pend_r && !out_free) begin
            state_nxt = S_CHK;
          end else begin
            if (qual) begin
              if (pend_r) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = OUT_TDATA_W'({pend_ext[FIELD_W-1:0], {FIELD_W{1'b0}}, ST_OK});
                out_user_nxt  = 1'b1;
                out_last_nxt  = 1'b0;
              end
              pend_nxt    = 1'b1;
              pend_id_nxt = rd_id;
            end
            idx_nxt   = idx_r + AW'(1);
            state_nxt = last_slot ? S_FIN : S_RD;
          end
        end else if (hit) begin
          found_nxt = 1'b1;
          match_nxt = idx_r;
          mhnd_nxt  = rd_hnd;
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = last_slot ? S_FIN : S_RD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = 1'b0;
          out_last_nxt  = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = S_IDLE;
          case (func_r)
            FN_LOOKUP: begin
              out_data_nxt = found_r ? OUT_TDATA_W'({mhnd_r, ST_OK})
                                     : OUT_TDATA_W'(ST_MISS);
            end
            FN_ADD: begin
              if (found_r || !free_ok) begin
                out_data_nxt = OUT_TDATA_W'(ST_REFUSED);
              end else begin
                ram_we             = 1'b1;
                used_nxt[free_idx] = 1'b1;
                rcmd.push          = 1'b1;
              end
            end
            FN_REMOVE: begin
              if (found_r) begin
                used_nxt[match_r] = 1'b0;
              end
              rcmd.drop    = 1'b1;
              out_data_nxt = found_r ? OUT_TDATA_W'(ST_OK) : OUT_TDATA_W'(ST_MISS);
            end
            FN_LIST_ALL, FN_LIST_FLUSH: begin
              if (pend_r) begin
                out_data_nxt = OUT_TDATA_W'({pend_ext[FIELD_W-1:0], {FIELD_W{1'b0}}, ST_OK});
                out_user_nxt = 1'b1;
              end
            end
            default: begin
              out_data_nxt = '0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      limit_r     <= LIMIT_W'(8);
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        limit_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r <= in_tuser;
      id_r   <= in_id;
      hnd_r  <= in_tdata[2*FIELD_W-1:FIELD_W];
    end
    idx_r      <= idx_nxt;
    found_r    <= found_nxt;
    match_r    <= match_nxt;
    mhnd_r     <= mhnd_nxt;
    pend_r     <= pend_nxt;
    pend_id_r  <= pend_id_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
`default_nettype wire

// ----- src/ncache_checker.sv -----
// ----------------------------------------------------------------------------
// ncache_checker
// Port-level checks of the node cache core, bound to the core module.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module ncache_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic [71:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic        in_tvalid,
  input wire logic        in_tready
);

  // a stalled result beat holds
  `NC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "out beat changed under stall")

  // only listed entries may be followed by more beats
  `NC_ASSERT(a_nonlast_item, !out_tvalid || out_tlast || out_tuser, "non-final beat without entry")

  // status is never the unused code
  `NC_ASSERT(a_status_code, !out_tvalid || (out_tdata[1:0] != 2'd3), "bad status code")

  // one operation at a time
  `NC_ASSERT_NEXT(a_one_op, in_tvalid && in_tready, !in_tready, "input taken while busy")

endmodule
bind node_cache_with_recency_list_core ncache_checker u_ncache_checker (.*);
`default_nettype wire
